[src/rpc_pkg.sv]
// Shared types and constants for the radix palindrome counter.
// No dependencies; every other file imports this package.
package rpc_pkg;

  localparam int RADIX_W   = 6;
  localparam int DIG_W     = 6;
  localparam int DCOUNT_W  = 6;
  localparam int COUNT_W   = 32;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_CMP,
    ST_DONE
  } state_t;

  // Commands from the sequencer to the digit row.
  typedef struct packed {
    logic clear;
    logic step;
    logic bit_in;
    logic shift;
  } dig_cmd_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end else begin
      return r;
    end
  endfunction

endpackage

[src/rpc_if.sv]
// Valid/ready channel interfaces for the request and result sides.
// Depends on rpc_pkg for the fixed field widths.
interface rpc_in_if #(parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface rpc_out_if
  import rpc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                is_palindrome;
  logic [DCOUNT_W-1:0] digit_count;
  logic [COUNT_W-1:0]  palindrome_count;
  logic                interval_end;

  modport source (output valid, output is_palindrome, output digit_count,
                  output palindrome_count, output interval_end, input ready);
  modport sink   (input valid, input is_palindrome, input digit_count,
                  input palindrome_count, input interval_end, output ready);
endinterface

[src/rpc_digits.sv]
// Row of digit cells that converts a bit stream, MSB first, into radix digits.
// Depends on rpc_pkg for the digit width and the command struct.
module rpc_digits
  import rpc_pkg::*;
#(
  parameter int MAX_DIGITS = 32,
  localparam int NW = $clog2(MAX_DIGITS + 1),
  localparam int IW = $clog2(MAX_DIGITS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dig_cmd_t           cmd,
  input  logic [RADIX_W-1:0] radix,
  input  logic [IW-1:0]      sel_idx,
  output logic [DIG_W-1:0]   low_digit,
  output logic [DIG_W-1:0]   sel_digit,
  output logic [NW-1:0]      digit_n
);

  logic [DIG_W-1:0]    dig_r   [MAX_DIGITS];
  logic [DIG_W-1:0]    dig_nxt [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] gen, prop;
  logic [MAX_DIGITS:0]   sum, carry;
  logic [NW-1:0]         n_r, n_nxt;
  logic                  grow;

  // Doubling a cell and adding the carry gives a value below twice the radix,
  // so one compare decides the carry out. A cell generates a carry when
  // 2d >= radix and passes the incoming one on when 2d + 1 == radix; the
  // resulting chain is resolved with a single add.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      gen[i]  = {dig_r[i], 1'b0} >= {1'b0, radix};
      prop[i] = {dig_r[i], 1'b1} == {1'b0, radix};
    end
    sum   = {1'b0, gen | prop} + {1'b0, gen} + {{MAX_DIGITS{1'b0}}, cmd.bit_in};
    carry = sum ^ {1'b0, (gen | prop) ^ gen};
  end

  always_comb begin
    logic [DIG_W:0] t;
    t = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      t = {dig_r[i], carry[i]};
      if (t >= {1'b0, radix}) begin
        dig_nxt[i] = DIG_W'(t - {1'b0, radix});
      end else begin
        dig_nxt[i] = t[DIG_W-1:0];
      end
    end
  end

  // A carry into the cell just above the top digit opens a new digit.
  assign grow  = (n_r < NW'(MAX_DIGITS)) && carry[n_r];
  assign n_nxt = cmd.clear ? NW'(1) : (cmd.step ? n_r + NW'(grow) : n_r);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int i = 0; i < MAX_DIGITS; i++) dig_r[i] <= '0;
    end else if (cmd.step) begin
      for (int i = 0; i < MAX_DIGITS; i++) dig_r[i] <= dig_nxt[i];
    end else if (cmd.shift) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) dig_r[i] <= dig_r[i+1];
      dig_r[MAX_DIGITS-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= NW'(1);
    end else begin
      n_r <= n_nxt;
    end
  end

  assign low_digit = dig_r[0];
  assign sel_digit = dig_r[sel_idx];
  assign digit_n   = n_r;

endmodule

[src/radix_palindrome_counter.sv]
// Radix palindrome counter: sequencer, interval counter and result register.
// Depends on rpc_pkg, the channel interfaces in rpc_if.sv and rpc_digits.
//
// Usage. Requests arrive on in_ch (value, last) under valid/ready; results
// leave on out_ch (is_palindrome, digit_count, palindrome_count,
// interval_end), one per request, in order. The radix is set through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce. Values below 2 act as 2 and values above 36 act as 36.
// Timing. The value is shifted into the digit row one bit per cycle, then
// the digit row is shifted down while its lowest digit is compared against
// its mirror, one pair per cycle; a mismatch ends the compare early. Once the
// result is registered the block returns to idle, where the next request is
// accepted. One request is in work at a time.
// Stalls. The result sits in an output register; the next request is taken
// and processed while it waits, and only the following result waits for it.
// Reset. rst_n is synchronous and active low; it sets the radix to 10,
// clears the palindrome count and empties the result register.
module radix_palindrome_counter
  import rpc_pkg::*;
#(
  parameter int MAX_DIGITS = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  rpc_in_if.sink             in_ch,
  rpc_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [RADIX_W-1:0] cfg_wdata
);

  localparam int NW = $clog2(MAX_DIGITS + 1);
  localparam int IW = $clog2(MAX_DIGITS);
  localparam int BW = $clog2(VALUE_BITS + 1);

  state_t                state_r, state_nxt;
  logic [RADIX_W-1:0]    radix_r;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [BW-1:0]         bits_r, bits_nxt;
  logic [IW-1:0]         p_r, p_nxt;
  logic                  pal_r, pal_nxt;
  logic                  last_r, last_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [COUNT_W-1:0]    count_inc;
  logic                  out_valid_r, out_valid_nxt;
  logic                  load;
  logic                  res_pal_r;
  logic [DCOUNT_W-1:0]   res_dcount_r;
  logic [COUNT_W-1:0]    res_count_r;
  logic                  res_end_r;
  dig_cmd_t              cmd;
  logic [DIG_W-1:0]      low_digit, sel_digit;
  logic [NW-1:0]         digit_n;

  rpc_digits #(.MAX_DIGITS(MAX_DIGITS)) u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .radix     (radix_r),
    .sel_idx   (p_r),
    .low_digit (low_digit),
    .sel_digit (sel_digit),
    .digit_n   (digit_n)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= clamp_radix(cfg_wdata);
    end
  end

  assign count_inc = (pal_r && (count_r != '1)) ? count_r + COUNT_W'(1) : count_r;

  always_comb begin
    state_nxt   = state_r;
    val_nxt     = val_r;
    bits_nxt    = bits_r;
    p_nxt       = p_r;
    pal_nxt     = pal_r;
    last_nxt    = last_r;
    count_nxt   = count_r;
    load        = 1'b0;
    cmd         = '0;
    in_ch.ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          val_nxt   = in_ch.value;
          last_nxt  = in_ch.last;
          bits_nxt  = BW'(VALUE_BITS);
          pal_nxt   = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step   = 1'b1;
        cmd.bit_in = val_r[VALUE_BITS-1];
        val_nxt    = val_r << 1;
        bits_nxt   = bits_r - BW'(1);
        if (bits_r == BW'(1)) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        p_nxt     = IW'(digit_n - NW'(1));
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // p_r points at the mirror of the digit now in the lowest cell.
        if (p_r == '0) begin
          state_nxt = ST_DONE;
        end else if (low_digit != sel_digit) begin
          pal_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          cmd.shift = 1'b1;
          if (p_r < IW'(3)) begin
            state_nxt = ST_DONE;
          end else begin
            p_nxt = p_r - IW'(2);
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load      = 1'b1;
          count_nxt = last_r ? '0 : count_inc;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    bits_r <= bits_nxt;
    p_r    <= p_nxt;
    pal_r  <= pal_nxt;
    last_r <= last_nxt;
    if (load) begin
      res_pal_r    <= pal_r;
      res_dcount_r <= DCOUNT_W'(digit_n);
      res_count_r  <= count_inc;
      res_end_r    <= last_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.is_palindrome    = res_pal_r;
  assign out_ch.digit_count      = res_dcount_r;
  assign out_ch.palindrome_count = res_count_r;
  assign out_ch.interval_end     = res_end_r;

  a_accept_starts_conv : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_CONV))
    else $error("accepted request did not start conversion");

  a_digit_n_range : assert property (@(posedge clk) disable iff (!rst_n)
    (digit_n != '0) && (digit_n <= NW'(MAX_DIGITS)))
    else $error("digit count out of range");

  a_pal_counted : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_palindrome) |-> (out_ch.palindrome_count != '0))
    else $error("palindrome reported with zero count");

  a_load_only_when_free : assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten while held");

endmodule
